/* sv/dpdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpdr_pkg: shared types and constants for the dual PWM duty ramp
// Register map codes, per-channel configuration and status records, and the
// direction-to-drive decode.
// ----------------------------------------------------------------------------
package dpdr_pkg;

  localparam int DUTY_W     = 8;
  localparam int STEP_W     = 8;
  localparam int WAIT_W     = 8;
  localparam int DIRN_W     = 8;
  localparam int DRIVE_W    = 2;
  localparam int WAIT_SCALE = 32;

  // Largest threshold the wait register can ask for; the counter never
  // climbs past its threshold, so this bounds the counter too.
  localparam int WaitMax = ((1 << WAIT_W) - 1) * WAIT_SCALE;
  localparam int CNT_W   = $clog2(WaitMax + 1);

  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int ADDR_W   = IDX_W + 2;
  localparam int DATA_W   = 32;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET_A    = 3'd0,
    REG_STEP_A      = 3'd1,
    REG_WAIT_A      = 3'd2,
    REG_DIRECTION_A = 3'd3,
    REG_TARGET_B    = 3'd4,
    REG_STEP_B      = 3'd5,
    REG_WAIT_B      = 3'd6,
    REG_DIRECTION_B = 3'd7
  } reg_idx_t;

  // Direction register codes
  localparam logic [DIRN_W-1:0] DIRN_FWD = 8'd1;
  localparam logic [DIRN_W-1:0] DIRN_BWD = 8'd2;

  // Pin pair codes: bit0 forward pin, bit1 backward pin
  localparam logic [DRIVE_W-1:0] DRV_FWD = 2'b01;
  localparam logic [DRIVE_W-1:0] DRV_BWD = 2'b10;

  typedef struct packed {
    logic [DUTY_W-1:0] target;
    logic [STEP_W-1:0] step;
    logic [WAIT_W-1:0] wait_units;
    logic [DIRN_W-1:0] direction;
  } chan_cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [DRIVE_W-1:0] drive;
    logic               settled;
  } chan_stat_t;

  typedef struct packed {
    chan_stat_t a;
    chan_stat_t b;
  } res_t;

  function automatic logic [DRIVE_W-1:0] next_drive(
    input logic [DIRN_W-1:0]  dirn,
    input logic [DRIVE_W-1:0] held
  );
    logic [DRIVE_W-1:0] drv;
    case (dirn)
      DIRN_FWD: drv = DRV_FWD;
      DIRN_BWD: drv = DRV_BWD;
      default:  drv = held;
    endcase
    return drv;
  endfunction

endpackage
`default_nettype wire

/* sv/dpdr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpdr_if: beat channels of the dual PWM duty ramp
// Tick request channel and status result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpdr_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface dpdr_out_if;
  logic                             valid;
  logic                             ready;
  logic [dpdr_pkg::DUTY_W-1:0]      duty_a;
  logic [dpdr_pkg::DUTY_W-1:0]      duty_b;
  logic [dpdr_pkg::DRIVE_W-1:0]     drive_a;
  logic [dpdr_pkg::DRIVE_W-1:0]     drive_b;
  logic                             settled_a;
  logic                             settled_b;

  modport source (output valid, output duty_a, output duty_b, output drive_a,
                  output drive_b, output settled_a, output settled_b, input ready);
  modport sink   (input valid, input duty_a, input duty_b, input drive_a,
                  input drive_b, input settled_a, input settled_b, output ready);
endinterface
`default_nettype wire

/* sv/dpdr_channel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpdr_channel: one duty ramp channel
// Holds duty, wait count and pin drive; steps toward target with clamp.
// ----------------------------------------------------------------------------
module dpdr_channel (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick,
  input  wire dpdr_pkg::chan_cfg_t  cfg,
  output dpdr_pkg::chan_stat_t      stat_nxt
);

  logic [dpdr_pkg::DUTY_W-1:0]  duty_r, duty_nxt;
  logic [dpdr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [dpdr_pkg::DRIVE_W-1:0] drive_r, drive_nxt;
  logic [dpdr_pkg::CNT_W-1:0]   thresh;
  logic [dpdr_pkg::DUTY_W:0]    up_sum;
  logic [dpdr_pkg::DUTY_W:0]    down_lim;

  always_comb begin
    thresh   = dpdr_pkg::CNT_W'(dpdr_pkg::WAIT_SCALE)
             * dpdr_pkg::CNT_W'(cfg.wait_units);
    up_sum   = {1'b0, duty_r} + {1'b0, cfg.step};
    down_lim = {1'b0, cfg.target} + {1'b0, cfg.step};

    duty_nxt  = duty_r;
    cnt_nxt   = cnt_r;
    drive_nxt = drive_r;
    if (tick) begin
      drive_nxt = dpdr_pkg::next_drive(cfg.direction, drive_r);
      if (duty_r != cfg.target) begin
        if (cnt_r >= thresh) begin
          cnt_nxt = '0;
          if (duty_r < cfg.target) begin
            duty_nxt = (up_sum > {1'b0, cfg.target}) ? cfg.target : up_sum[dpdr_pkg::DUTY_W-1:0];
          end else begin
            duty_nxt = ({1'b0, duty_r} > down_lim) ? duty_r - cfg.step : cfg.target;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end

    stat_nxt.duty    = duty_nxt;
    stat_nxt.drive   = drive_nxt;
    stat_nxt.settled = (duty_nxt == cfg.target);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= '0;
      cnt_r   <= '0;
      drive_r <= dpdr_pkg::DRV_FWD;
    end else begin
      duty_r  <= duty_nxt;
      cnt_r   <= cnt_nxt;
      drive_r <= drive_nxt;
    end
  end

  // settled channel must not move on a tick
  a_settled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    tick && (duty_r == cfg.target) |=> $stable(duty_r))
    else $error("settled duty moved");

  // every duty move clears the wait count
  a_move_clears: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(duty_r) |-> (cnt_r == '0))
    else $error("duty moved without clearing count");

  // count never climbs past the largest threshold
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dpdr_pkg::CNT_W'(dpdr_pkg::WaitMax))
    else $error("wait count out of range");

  // pin pair is never both off or both on
  a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_r == dpdr_pkg::DRV_FWD) || (drive_r == dpdr_pkg::DRV_BWD))
    else $error("illegal drive code");

endmodule
`default_nettype wire

/* sv/dual_pwm_duty_ramp_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_pwm_duty_ramp_core: two-channel PWM duty slew-rate limiter
// APB register file, two ramp channels and a two-beat result buffer.
// ----------------------------------------------------------------------------
// Each input beat carries one advance bit. With advance set, both channels
// take one control tick: the pin pair follows the direction register and
// the duty either waits (count up) or, once the count reaches wait*32,
// moves one step toward target, clamped at target, and the count clears.
// With advance clear the beat only reports. Every input beat yields exactly
// one result beat holding both duties, pin pairs and settled flags as they
// stand after the tick. Throughput is one beat per clock while input ready is
// high; a result is in the head register the cycle after it is accepted when
// the head register is free, and otherwise waits in the skid slot until the
// head beat is taken. The two-entry result buffer keeps input ready high
// while one result is still waiting downstream, so the input stalls only when
// two results are queued. Registers are written through APB (byte address
// 4*index) and are meant to change only while no beat is in flight.
// ----------------------------------------------------------------------------
module dual_pwm_duty_ramp_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  dpdr_in_if.sink                           in_ch,
  dpdr_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dpdr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [dpdr_pkg::DATA_W-1:0]  pwdata,
  output logic      [dpdr_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  // --- register file --------------------------------------------------------
  dpdr_pkg::chan_cfg_t  cfg_a_r, cfg_b_r;
  dpdr_pkg::reg_idx_t   reg_idx;
  logic                 wr_en;
  logic [7:0]           wr_byte;

  assign pready  = 1'b1;
  assign reg_idx = dpdr_pkg::reg_idx_t'(paddr[dpdr_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign wr_byte = pwdata[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_a_r <= '{target: '0, step: '0, wait_units: '0, direction: dpdr_pkg::DIRN_FWD};
      cfg_b_r <= '{target: '0, step: '0, wait_units: '0, direction: dpdr_pkg::DIRN_FWD};
    end else if (wr_en) begin
      case (reg_idx)
        dpdr_pkg::REG_TARGET_A:    cfg_a_r.target     <= wr_byte;
        dpdr_pkg::REG_STEP_A:      cfg_a_r.step       <= wr_byte;
        dpdr_pkg::REG_WAIT_A:      cfg_a_r.wait_units <= wr_byte;
        dpdr_pkg::REG_DIRECTION_A: cfg_a_r.direction  <= wr_byte;
        dpdr_pkg::REG_TARGET_B:    cfg_b_r.target     <= wr_byte;
        dpdr_pkg::REG_STEP_B:      cfg_b_r.step       <= wr_byte;
        dpdr_pkg::REG_WAIT_B:      cfg_b_r.wait_units <= wr_byte;
        dpdr_pkg::REG_DIRECTION_B: cfg_b_r.direction  <= wr_byte;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dpdr_pkg::REG_TARGET_A:    prdata = dpdr_pkg::DATA_W'(cfg_a_r.target);
      dpdr_pkg::REG_STEP_A:      prdata = dpdr_pkg::DATA_W'(cfg_a_r.step);
      dpdr_pkg::REG_WAIT_A:      prdata = dpdr_pkg::DATA_W'(cfg_a_r.wait_units);
      dpdr_pkg::REG_DIRECTION_A: prdata = dpdr_pkg::DATA_W'(cfg_a_r.direction);
      dpdr_pkg::REG_TARGET_B:    prdata = dpdr_pkg::DATA_W'(cfg_b_r.target);
      dpdr_pkg::REG_STEP_B:      prdata = dpdr_pkg::DATA_W'(cfg_b_r.step);
      dpdr_pkg::REG_WAIT_B:      prdata = dpdr_pkg::DATA_W'(cfg_b_r.wait_units);
      dpdr_pkg::REG_DIRECTION_B: prdata = dpdr_pkg::DATA_W'(cfg_b_r.direction);
      default:                   prdata = '0;
    endcase
  end

  // --- handshake ------------------------------------------------------------
  logic push, pop, tick;
  logic out_v_r, skid_v_r;
  dpdr_pkg::res_t out_r, skid_r, res_new;

  assign in_ch.ready = !skid_v_r;           // room while the skid slot is free
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_v_r && out_ch.ready;
  assign tick        = push && in_ch.advance;

  // --- ramp channels: state moves only on an accepted tick -----------------
  dpdr_channel u_chan_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .cfg      (cfg_a_r),
    .stat_nxt (res_new.a)
  );

  dpdr_channel u_chan_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (tick),
    .cfg      (cfg_b_r),
    .stat_nxt (res_new.b)
  );

  // --- two-beat result buffer: head register plus skid slot ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || pop) begin
        if (skid_v_r) begin
          out_v_r  <= 1'b1;
          skid_v_r <= push;
        end else begin
          out_v_r  <= push;
        end
      end else if (push) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || pop) begin
      if (skid_v_r) begin
        out_r <= skid_r;
        if (push) begin
          skid_r <= res_new;
        end
      end else if (push) begin
        out_r <= res_new;
      end
    end else if (push) begin
      skid_r <= res_new;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.duty_a    = out_r.a.duty;
  assign out_ch.duty_b    = out_r.b.duty;
  assign out_ch.drive_a   = out_r.a.drive;
  assign out_ch.drive_b   = out_r.b.drive;
  assign out_ch.settled_a = out_r.a.settled;
  assign out_ch.settled_b = out_r.b.settled;

  // skid slot is only ever filled behind a waiting head beat
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid beat without head beat");

  // an accepted beat always shows up at the head next cycle when it was empty
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push && !out_v_r |=> out_v_r)
    else $error("accepted beat lost");

  // a stalled head beat stays put until taken
  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_r))
    else $error("stalled head beat changed");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: dual PWM duty ramp, self-checking
// Feeds tick beats through the input channel, sets up both ramp channels
// over APB between bursts, and checks every status beat against a local
// model of the duty slew, wait count and pin pair logic.
// ----------------------------------------------------------------------------
module testbench;
  import dpdr_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 200;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  dpdr_in_if  in_ch ();
  dpdr_out_if out_ch ();

  dual_pwm_duty_ramp_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow of the register file and the ramp state
  chan_cfg_t          cfg_a, cfg_b;
  logic [DUTY_W-1:0]  duty_a_q, duty_b_q;
  logic [15:0]        count_a_q, count_b_q;
  logic [DRIVE_W-1:0] drive_a_q, drive_b_q;

  logic tick_queue[$];   // advance bits waiting to be sent
  res_t status_due[$];   // status beats owed by the block, oldest first

  int beats_issued  = 0;
  int beats_checked = 0;
  int errors        = 0;
  int cycles        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic [DRIVE_W-1:0] pin_pair(input logic [DIRN_W-1:0]  dirn,
                                                  input logic [DRIVE_W-1:0] held);
    if (dirn == DIRN_FWD) return DRV_FWD;
    if (dirn == DIRN_BWD) return DRV_BWD;
    return held;
  endfunction

  // One tick of one channel: wait, or step toward target clamped there.
  function automatic void slew_duty(inout logic [DUTY_W-1:0] duty,
                                    inout logic [15:0] count,
                                    input chan_cfg_t cfg);
    int threshold, d, tgt, stp;
    threshold = int'(cfg.wait_units) * WAIT_SCALE;
    d   = int'(duty);
    tgt = int'(cfg.target);
    stp = int'(cfg.step);
    if (d == tgt) return;   // settled: count holds
    if (int'(count) >= threshold) begin
      if (d < tgt) d = (d + stp > tgt) ? tgt : d + stp;
      else         d = (d > tgt + stp) ? d - stp : tgt;
      duty  = d[DUTY_W-1:0];
      count = '0;
    end else if (count != 16'hFFFF) begin
      count = count + 16'd1;
    end
  endfunction

  function automatic res_t next_status(input logic adv);
    res_t r;
    if (adv) begin
      drive_a_q = pin_pair(cfg_a.direction, drive_a_q);
      drive_b_q = pin_pair(cfg_b.direction, drive_b_q);
      slew_duty(duty_b_q, count_b_q, cfg_b);
      slew_duty(duty_a_q, count_a_q, cfg_a);
    end
    r.a.duty    = duty_a_q;
    r.a.drive   = drive_a_q;
    r.a.settled = (duty_a_q == cfg_a.target);
    r.b.duty    = duty_b_q;
    r.b.drive   = drive_b_q;
    r.b.settled = (duty_b_q == cfg_b.target);
    return r;
  endfunction

  // Tick driver: holds a beat until taken, then maybe idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.advance <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) status_due.push_back(next_status(in_ch.advance));
      if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid   <= 1'b1;
        in_ch.advance <= tick_queue.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Status monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: status beat with nothing outstanding: duty %0d/%0d", $realtime,
                     out_ch.duty_a, out_ch.duty_b);
        end else begin
          want = status_due.pop_front();
          if (out_ch.duty_a !== want.a.duty || out_ch.duty_b !== want.b.duty ||
              out_ch.drive_a !== want.a.drive || out_ch.drive_b !== want.b.drive ||
              out_ch.settled_a !== want.a.settled || out_ch.settled_b !== want.b.settled) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display({"%0t: status mismatch: expected duty %0d/%0d drive %0d/%0d ",
                        "settled %0b/%0b, got duty %0d/%0d drive %0d/%0d settled %0b/%0b"},
                       $realtime, want.a.duty, want.b.duty, want.a.drive, want.b.drive,
                       want.a.settled, want.b.settled, out_ch.duty_a, out_ch.duty_b,
                       out_ch.drive_a, out_ch.drive_b, out_ch.settled_a, out_ch.settled_b);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // APB write: setup, access, register taken on the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};   // upper bits are don't-care
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TARGET_A:    cfg_a.target     = val;
      REG_STEP_A:      cfg_a.step       = val;
      REG_WAIT_A:      cfg_a.wait_units = val;
      REG_DIRECTION_A: cfg_a.direction  = val;
      REG_TARGET_B:    cfg_b.target     = val;
      REG_STEP_B:      cfg_b.step       = val;
      REG_WAIT_B:      cfg_b.wait_units = val;
      REG_DIRECTION_B: cfg_b.direction  = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (beats_checked < beats_issued) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic run_ticks(input int n, input int tick_pct);
    @(negedge clk);
    repeat (n) begin
      tick_queue.push_back($urandom_range(99) < tick_pct);
      beats_issued++;
    end
    drain();
  endtask

  // Mostly short waits so ramps actually move; targets and steps hit the rails
  function automatic logic [7:0] pick_value(input reg_idx_t idx);
    logic [7:0] v;
    v = 8'($urandom);
    case (idx)
      REG_WAIT_A, REG_WAIT_B: begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: v = 8'h00;
          5, 6, 7:       v = 8'($urandom_range(1, 2));
          8:             v = 8'hFF;
          default: ;
        endcase
      end
      REG_DIRECTION_A, REG_DIRECTION_B: begin
        if ($urandom_range(3) != 0) v = $urandom_range(1) ? DIRN_FWD : DIRN_BWD;
      end
      REG_STEP_A, REG_STEP_B: begin
        case ($urandom_range(3))
          0: v = $urandom_range(1) ? 8'hFF : 8'h00;
          1: v = 8'($urandom_range(1, 16));
          default: ;
        endcase
      end
      default: begin
        if ($urandom_range(4) == 0) v = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    endcase
    return v;
  endfunction

  // Rewrite a random subset; every channel keeps its wait count
  task automatic shuffle_config();
    reg_idx_t idx;
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = reg_idx_t'(i);
      if ($urandom_range(99) < 40) write_reg(idx, pick_value(idx));
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.advance = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_a = '{target: '0, step: '0, wait_units: '0, direction: DIRN_FWD};
    cfg_b = '{target: '0, step: '0, wait_units: '0, direction: DIRN_FWD};
    duty_a_q  = '0;
    duty_b_q  = '0;
    count_a_q = '0;
    count_b_q = '0;
    drive_a_q = DRV_FWD;
    drive_b_q = DRV_FWD;
    send_idle_pct = 26;
    recv_idle_pct = 76;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // out of reset: report only, then a tick with both channels settled
    run_ticks(1, 0);
    run_ticks(1, 100);

    // zero wait, large steps: A climbs and clamps at full scale, B lands in
    // one clamped step; A swaps pins, B holds on an unknown direction code
    write_reg(REG_STEP_A, 8'd100);
    write_reg(REG_TARGET_A, 8'hFF);
    write_reg(REG_STEP_B, 8'hFF);
    write_reg(REG_TARGET_B, 8'd200);
    write_reg(REG_DIRECTION_A, DIRN_BWD);
    write_reg(REG_DIRECTION_B, 8'h00);
    run_ticks(2, 100);
    run_ticks(1, 0);
    run_ticks(2, 100);

    // full-scale step down clamps at zero; zero step leaves B put
    write_reg(REG_TARGET_A, 8'h00);
    write_reg(REG_STEP_A, 8'hFF);
    write_reg(REG_TARGET_B, 8'd3);
    write_reg(REG_STEP_B, 8'h00);
    write_reg(REG_DIRECTION_A, DIRN_FWD);
    write_reg(REG_DIRECTION_B, DIRN_BWD);
    run_ticks(3, 100);

    // longest wait builds the counts; dropping A's wait to zero mid-ramp steps it at once
    write_reg(REG_WAIT_A, 8'hFF);
    write_reg(REG_TARGET_A, 8'd10);
    write_reg(REG_STEP_A, 8'd1);
    write_reg(REG_WAIT_B, 8'hFF);
    write_reg(REG_STEP_B, 8'd7);
    write_reg(REG_DIRECTION_A, 8'hFF);
    write_reg(REG_DIRECTION_B, 8'd3);
    run_ticks(5, 100);
    write_reg(REG_WAIT_A, 8'h00);
    write_reg(REG_WAIT_B, 8'h01);
    run_ticks(3, 100);

    // random bursts: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 26 : 0;
      repeat (11) begin
        shuffle_config();
        run_ticks($urandom_range(40, 60), 85);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (status_due.size() != 0) begin
      errors++;
      $display("%0t: %0d status beats never arrived", $realtime, status_due.size());
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
